>>> design/complex_arithmetic_unit_macros.svh
// assertion macros shared by the complex arithmetic unit modules
// no dependencies; included by the files that carry assertions
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/cau_pkg.sv
// types and constants of the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int FIELD_W = 32;
    localparam int QDEPTH  = 4;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CONJ  = 3'd4,
        OP_MAGSQ = 3'd5,
        OP_MAG   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        KIND_FAST = 2'd0,
        KIND_PROD = 2'd1,
        KIND_DIV  = 2'd2,
        KIND_SQRT = 2'd3
    } kind_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        op_t                       op;
        kind_t                     kind;
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;
        logic signed [FIELD_W-1:0] c;
        logic signed [FIELD_W-1:0] d;
    } item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] re;
        logic signed [FIELD_W-1:0] im;
        logic [1:0]                status;
    } res_t;

endpackage

>>> design/cau_in_if.sv
// input channel of the complex arithmetic unit
// no dependencies
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;

    modport source (output valid, output opcode, output a_real, output a_imag,
                    output b_real, output b_imag, input ready);
    modport sink   (input valid, input opcode, input a_real, input a_imag,
                    input b_real, input b_imag, output ready);
endinterface

>>> design/cau_out_if.sv
// result channel of the complex arithmetic unit
// no dependencies
interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
    logic [1:0]         status;

    modport source (output valid, output out_real, output out_imag, output status,
                    input ready);
    modport sink   (input valid, input out_real, input out_imag, input status,
                     output ready);
endinterface

>>> design/cau_front.sv
// front end: accepts items, narrows operands, classifies the opcode, queues
// depends on cau_pkg, cau_in_if and complex_arithmetic_unit_macros.svh
`include "complex_arithmetic_unit_macros.svh"

module cau_front #(
    parameter int WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    cau_in_if.sink         in_ch,
    output cau_pkg::item_t q_item,
    output logic           q_vld,
    input  logic           q_rdy
);

    localparam int SHIFT = cau_pkg::FIELD_W - WIDTH;
    localparam int PTR_W = $clog2(cau_pkg::QDEPTH);
    localparam int CNT_W = $clog2(cau_pkg::QDEPTH + 1);

    cau_pkg::item_t mem_reg [0:cau_pkg::QDEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    cau_pkg::item_t cls;
    logic push, pop;

    // low WIDTH bits, sign extended
    function automatic logic signed [31:0] sext(input logic [31:0] v);
        logic signed [31:0] t;
        t = signed'(v << SHIFT);
        return t >>> SHIFT;
    endfunction

    always_comb
    begin
        cls.op = cau_pkg::op_t'(in_ch.opcode);
        cls.a  = sext(in_ch.a_real);
        cls.b  = sext(in_ch.a_imag);
        cls.c  = sext(in_ch.b_real);
        cls.d  = sext(in_ch.b_imag);
        case (cls.op)
            cau_pkg::OP_MUL, cau_pkg::OP_MAGSQ: cls.kind = cau_pkg::KIND_PROD;
            cau_pkg::OP_DIV:                    cls.kind = cau_pkg::KIND_DIV;
            cau_pkg::OP_MAG:                    cls.kind = cau_pkg::KIND_SQRT;
            default:                            cls.kind = cau_pkg::KIND_FAST;
        endcase
    end

    assign in_ch.ready = (cnt_reg != CNT_W'(cau_pkg::QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_vld       = (cnt_reg != '0);
    assign pop         = q_vld && q_rdy;
    assign q_item      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    `CAU_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(cau_pkg::QDEPTH), "queue count beyond depth")
    `CAU_ASSERT_NXT(a_cnt_push, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + CNT_W'(1), "queue count missed a push")

endmodule

>>> design/cau_back.sv
// back end: product, sum, restoring divide and square root pipeline with output register
// depends on cau_pkg, cau_out_if and complex_arithmetic_unit_macros.svh
`include "complex_arithmetic_unit_macros.svh"

module cau_back #(
    parameter int WIDTH     = 32,
    parameter int FRAC_BITS = 28
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cau_pkg::item_t q_item,
    input  logic           q_vld,
    output logic           q_rdy,
    cau_out_if.source      out_ch
);

    localparam int W  = WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int XW = 64 + FRAC_BITS;
    localparam int SQ_STEPS = 32;
    localparam logic signed [66:0] MAXV = (67'sd1 <<< (W - 1)) - 67'sd1;
    localparam logic signed [66:0] MINV = -(67'sd1 <<< (W - 1));

    typedef struct packed {
        cau_pkg::op_t       op;
        cau_pkg::kind_t     kind;
        logic signed [63:0] m0;
        logic signed [63:0] m1;
        logic signed [63:0] ad;
        logic signed [63:0] bc;
        logic signed [63:0] cc;
        logic signed [63:0] dd;
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic               ovf;
    } b1_t;

    typedef struct packed {
        cau_pkg::op_t       op;
        cau_pkg::kind_t     kind;
        logic signed [64:0] s1;
        logic signed [64:0] s2;
        logic [63:0]        den;
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic               ovf;
    } b2_t;

    typedef struct packed {
        cau_pkg::kind_t      kind;
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic                ovf;
        logic                neg1;
        logic                neg2;
        logic                divz;
        logic [XW-1:0]       x1;
        logic [XW-1:0]       x2;
        logic [63:0]         r1;
        logic [63:0]         r2;
        logic [W:0]          q1;
        logic [W:0]          q2;
        logic                big1;
        logic                big2;
        logic [63:0]         den;
        logic [63:0]         sq_n;
        logic [63:0]         sq_r;
    } stg_t;

    logic en;
    b1_t  b1_reg, b1_next;
    b2_t  b2_reg, b2_next;
    logic b1_vld_reg, b2_vld_reg;
    stg_t stg_reg [0:XW];
    stg_t stg_next [0:XW];
    logic stg_vld_reg [0:XW];
    cau_pkg::res_t out_reg, out_next;
    logic out_vld_reg;

    // saturate to WIDTH bits; top bit of the result flags overflow
    function automatic logic [W:0] sat(input logic signed [66:0] v);
        if (v > MAXV)
        begin
            return {1'b1, MAXV[W-1:0]};
        end
        else if (v < MINV)
        begin
            return {1'b1, MINV[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    assign en    = !out_vld_reg || out_ch.ready;
    assign q_rdy = en;

    // products
    always_comb
    begin
        logic signed [31:0] mx, my;
        logic [W:0] sr, si;
        mx = (q_item.kind == cau_pkg::KIND_PROD || q_item.kind == cau_pkg::KIND_SQRT) &&
             q_item.op != cau_pkg::OP_MUL ? q_item.a : q_item.c;
        my = (q_item.kind == cau_pkg::KIND_PROD || q_item.kind == cau_pkg::KIND_SQRT) &&
             q_item.op != cau_pkg::OP_MUL ? q_item.b : q_item.d;
        b1_next.op   = q_item.op;
        b1_next.kind = q_item.kind;
        b1_next.m0   = 64'(q_item.a) * 64'(mx);
        b1_next.m1   = 64'(q_item.b) * 64'(my);
        b1_next.ad   = 64'(q_item.a) * 64'(q_item.d);
        b1_next.bc   = 64'(q_item.b) * 64'(q_item.c);
        b1_next.cc   = 64'(q_item.c) * 64'(q_item.c);
        b1_next.dd   = 64'(q_item.d) * 64'(q_item.d);
        sr = '0;
        si = '0;
        case (q_item.op)
            cau_pkg::OP_ADD:
            begin
                sr = sat(67'(q_item.a) + 67'(q_item.c));
                si = sat(67'(q_item.b) + 67'(q_item.d));
            end
            cau_pkg::OP_SUB:
            begin
                sr = sat(67'(q_item.a) - 67'(q_item.c));
                si = sat(67'(q_item.b) - 67'(q_item.d));
            end
            cau_pkg::OP_CONJ:
            begin
                sr = {1'b0, q_item.a[W-1:0]};
                si = sat(-67'(q_item.b));
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        b1_next.re  = signed'(sr[W-1:0]);
        b1_next.im  = signed'(si[W-1:0]);
        b1_next.ovf = sr[W] | si[W];
    end

    // exact sums
    always_comb
    begin
        b2_next.op   = b1_reg.op;
        b2_next.kind = b1_reg.kind;
        b2_next.re   = b1_reg.re;
        b2_next.im   = b1_reg.im;
        b2_next.ovf  = b1_reg.ovf;
        b2_next.s1   = (b1_reg.op == cau_pkg::OP_MUL) ? 65'(b1_reg.m0) - 65'(b1_reg.m1)
                                                      : 65'(b1_reg.m0) + 65'(b1_reg.m1);
        b2_next.s2   = (b1_reg.op == cau_pkg::OP_DIV) ? 65'(b1_reg.bc) - 65'(b1_reg.ad)
                                                      : 65'(b1_reg.ad) + 65'(b1_reg.bc);
        b2_next.den  = 64'(65'(b1_reg.cc) + 65'(b1_reg.dd));
    end

    // rounding of products, set-up of divider and root
    always_comb
    begin
        logic [W:0] sr, si;
        logic [63:0] abs1, abs2;
        sr = '0;
        si = '0;
        case (b2_reg.kind)
            cau_pkg::KIND_FAST:
            begin
                sr = {b2_reg.ovf, b2_reg.re};
                si = {1'b0, b2_reg.im};
            end
            cau_pkg::KIND_PROD:
            begin
                sr = sat(67'(b2_reg.s1 >>> F));
                if (b2_reg.op == cau_pkg::OP_MUL)
                begin
                    si = sat(67'(b2_reg.s2 >>> F));
                end
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        abs1 = b2_reg.s1[64] ? 64'(-b2_reg.s1) : b2_reg.s1[63:0];
        abs2 = b2_reg.s2[64] ? 64'(-b2_reg.s2) : b2_reg.s2[63:0];
        stg_next[0].kind = b2_reg.kind;
        stg_next[0].re   = signed'(sr[W-1:0]);
        stg_next[0].im   = signed'(si[W-1:0]);
        stg_next[0].ovf  = sr[W] | si[W];
        stg_next[0].neg1 = b2_reg.s1[64];
        stg_next[0].neg2 = b2_reg.s2[64];
        stg_next[0].divz = (b2_reg.den == '0);
        stg_next[0].x1   = XW'(abs1) << F;
        stg_next[0].x2   = XW'(abs2) << F;
        stg_next[0].r1   = '0;
        stg_next[0].r2   = '0;
        stg_next[0].q1   = '0;
        stg_next[0].q2   = '0;
        stg_next[0].big1 = 1'b0;
        stg_next[0].big2 = 1'b0;
        stg_next[0].den  = b2_reg.den;
        stg_next[0].sq_n = b2_reg.s1[63:0];
        stg_next[0].sq_r = '0;
    end

    // one quotient bit per stage for both parts, one root bit in the first stages
    for (genvar k = 1; k <= XW; k++)
    begin : g_stage
        localparam logic [63:0] SQ_BIT = (k <= SQ_STEPS) ? (64'd1 << (64 - 2 * k)) : 64'd0;

        always_comb
        begin
            logic [64:0] t1, t2;
            logic [63:0] ts;
            stg_next[k] = stg_reg[k-1];
            t1 = {stg_reg[k-1].r1, stg_reg[k-1].x1[XW-1]};
            t2 = {stg_reg[k-1].r2, stg_reg[k-1].x2[XW-1]};
            stg_next[k].x1   = stg_reg[k-1].x1 << 1;
            stg_next[k].x2   = stg_reg[k-1].x2 << 1;
            stg_next[k].big1 = stg_reg[k-1].big1 | stg_reg[k-1].q1[W];
            stg_next[k].big2 = stg_reg[k-1].big2 | stg_reg[k-1].q2[W];
            if (t1 >= {1'b0, stg_reg[k-1].den})
            begin
                stg_next[k].r1 = 64'(t1 - {1'b0, stg_reg[k-1].den});
                stg_next[k].q1 = {stg_reg[k-1].q1[W-1:0], 1'b1};
            end
            else
            begin
                stg_next[k].r1 = t1[63:0];
                stg_next[k].q1 = {stg_reg[k-1].q1[W-1:0], 1'b0};
            end
            if (t2 >= {1'b0, stg_reg[k-1].den})
            begin
                stg_next[k].r2 = 64'(t2 - {1'b0, stg_reg[k-1].den});
                stg_next[k].q2 = {stg_reg[k-1].q2[W-1:0], 1'b1};
            end
            else
            begin
                stg_next[k].r2 = t2[63:0];
                stg_next[k].q2 = {stg_reg[k-1].q2[W-1:0], 1'b0};
            end
            ts = stg_reg[k-1].sq_r + SQ_BIT;
            if (SQ_BIT != '0)
            begin
                if (stg_reg[k-1].sq_n >= ts)
                begin
                    stg_next[k].sq_n = stg_reg[k-1].sq_n - ts;
                    stg_next[k].sq_r = (stg_reg[k-1].sq_r >> 1) + SQ_BIT;
                end
                else
                begin
                    stg_next[k].sq_r = stg_reg[k-1].sq_r >> 1;
                end
            end
        end
    end

    for (genvar k = 0; k <= XW; k++)
    begin : g_stage_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                stg_vld_reg[k] <= (k == 0) ? b2_vld_reg : stg_vld_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // final selection and saturation
    always_comb
    begin
        logic signed [66:0] v1, v2;
        logic [W:0] sr, si;
        stg_t f;
        f  = stg_reg[XW];
        v1 = f.big1 ? (67'sd1 <<< W) : signed'(67'(f.q1));
        v2 = f.big2 ? (67'sd1 <<< W) : signed'(67'(f.q2));
        if (f.neg1)
        begin
            v1 = -v1;
        end
        if (f.neg2)
        begin
            v2 = -v2;
        end
        sr = '0;
        si = '0;
        out_next.status = cau_pkg::ST_OK;
        case (f.kind)
            cau_pkg::KIND_DIV:
            begin
                if (!f.divz)
                begin
                    sr = sat(v1);
                    si = sat(v2);
                end
            end
            cau_pkg::KIND_SQRT:
            begin
                sr = sat(signed'(67'(f.sq_r)));
            end
            default:
            begin
                sr = {f.ovf, f.re};
                si = {1'b0, f.im};
            end
        endcase
        out_next.re = 32'(signed'(sr[W-1:0]));
        out_next.im = 32'(signed'(si[W-1:0]));
        if (f.kind == cau_pkg::KIND_DIV && f.divz)
        begin
            out_next.status = cau_pkg::ST_DIVZ;
        end
        else if (sr[W] || si[W])
        begin
            out_next.status = cau_pkg::ST_OVF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_vld_reg  <= q_vld;
            b2_vld_reg  <= b1_vld_reg;
            out_vld_reg <= stg_vld_reg[XW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            out_reg <= out_next;
        end
    end

    assign out_ch.valid    = out_vld_reg;
    assign out_ch.out_real = out_reg.re;
    assign out_ch.out_imag = out_reg.im;
    assign out_ch.status   = out_reg.status;

    `CAU_ASSERT_IMP(a_divz_zero, clk, rst_n, out_vld_reg && out_reg.status == cau_pkg::ST_DIVZ, out_reg.re == '0 && out_reg.im == '0, "divide by zero item with nonzero result")
    `CAU_ASSERT_IMP(a_status_code, clk, rst_n, out_vld_reg, out_reg.status == cau_pkg::ST_OK || out_reg.status == cau_pkg::ST_OVF || out_reg.status == cau_pkg::ST_DIVZ, "undefined status code")
    `CAU_ASSERT_NXT(a_pipe_move, clk, rst_n, b1_vld_reg && en, b2_vld_reg, "item lost between product and sum stages")

endmodule

>>> design/complex_arithmetic_unit.sv
// Complex arithmetic unit in signed fixed point (WIDTH bits, FRAC_BITS fraction bits):
// add, subtract, multiply, divide, conjugate, squared magnitude and magnitude, with
// saturation and a status code per result. One item is accepted every cycle while the
// input queue has room; the pipeline holds while a result waits on the output channel.
// Each item passes through the input queue, the product register, the exact sums,
// rounding and set-up, then one stage per quotient bit of the restoring divider
// (64 + FRAC_BITS stages, the square root running in the first 32 of them), then the
// output register. Every operation goes through the same stages, so results leave in
// order.
// Depends on cau_pkg, cau_in_if, cau_out_if, cau_front and cau_back.
module complex_arithmetic_unit #(
    parameter int WIDTH     = 32,
    parameter int FRAC_BITS = 28
) (
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    in_ch,
    cau_out_if.source out_ch
);

    cau_pkg::item_t q_item;
    logic           q_vld;
    logic           q_rdy;

    cau_front #(
        .WIDTH(WIDTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .q_item(q_item),
        .q_vld (q_vld),
        .q_rdy (q_rdy)
    );

    cau_back #(
        .WIDTH    (WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_item(q_item),
        .q_vld (q_vld),
        .q_rdy (q_rdy),
        .out_ch(out_ch)
    );

endmodule
